FILE: rtl/register_memory_taint_tracker_top_defines.svh
// assertion helpers used by the taint tracker back end (rmtt_back)
`ifndef REGISTER_MEMORY_TAINT_TRACKER_TOP_DEFINES_SVH
`define REGISTER_MEMORY_TAINT_TRACKER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RMTT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmtt check failed");

// antecedent implies consequent in the next cycle
`define RMTT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmtt check failed");

`endif

FILE: rtl/rmtt_pkg.sv
package rmtt_pkg;

  localparam int ADDR_W = 48;
  localparam int REG_W  = 5;
  localparam int MASK_W = 28;
  localparam int NUM_TRACKED = 28;

  localparam logic [ADDR_W-1:0] LIB_RESET = 48'h070000000000;

  localparam logic [2:0] ACT_MARK  = 3'd0;
  localparam logic [2:0] ACT_LOAD  = 3'd1;
  localparam logic [2:0] ACT_STORE = 3'd2;
  localparam logic [2:0] ACT_MOVE  = 3'd3;
  localparam logic [2:0] ACT_USE   = 3'd4;

  localparam logic [3:0] TWO_OPERANDS = 4'd2;

  localparam logic [1:0] RK_READ   = 2'd0;
  localparam logic [1:0] RK_WRITE  = 2'd1;
  localparam logic [1:0] RK_FOLLOW = 2'd2;
  localparam logic [1:0] RK_SPREAD = 2'd3;

  typedef enum logic [2:0] {
    OP_MARK,
    OP_LOAD,
    OP_STORE,
    OP_MOVE,
    OP_USE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] ia;
    logic [ADDR_W-1:0] ma;
    logic [REG_W-1:0]  pr;
    logic [REG_W-1:0]  wr;
  } item_t;

  // register code and the narrower codes after it in its group
  function automatic logic [MASK_W-1:0] span_of(input logic [REG_W-1:0] r);
    logic [REG_W-1:0]  last;
    logic [MASK_W-1:0] s;
    if (r <= 5'd5) last = 5'd5;
    else if (r <= 5'd10) last = 5'd10;
    else if (r <= 5'd15) last = 5'd15;
    else if (r <= 5'd20) last = 5'd20;
    else if (r <= 5'd24) last = 5'd24;
    else last = 5'd28;
    for (int i = 0; i < MASK_W; i++) begin
      s[i] = (r != '0) && (r <= 5'(NUM_TRACKED)) &&
             (i + 1 >= int'(r)) && (i + 1 <= int'(last));
    end
    return s;
  endfunction

  function automatic logic is_tainted(input logic [MASK_W-1:0] mask,
                                      input logic [REG_W-1:0] r);
    logic t;
    t = 1'b0;
    if (r != '0 && r <= 5'(NUM_TRACKED)) t = mask[5'(r - 5'd1)];
    return t;
  endfunction

endpackage

FILE: rtl/rmtt_queue.sv
module rmtt_queue
  import rmtt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  not_empty,
  output logic  full
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/rmtt_front.sv
module rmtt_front
  import rmtt_pkg::*;
(
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        action,
  input  logic [ADDR_W-1:0] instruction_address,
  input  logic [ADDR_W-1:0] mem_address,
  input  logic [3:0]        operand_count,
  input  logic [REG_W-1:0]  primary_register,
  input  logic [REG_W-1:0]  written_register,
  input  logic              q_full,
  input  logic              clearing,
  output logic              push,
  output item_t             item
);

  logic effective;
  op_t  op;

  assign in_ready = !q_full && !clearing;

  // events that cannot change state or report are dropped here
  always_comb begin
    effective = 1'b0;
    op        = OP_USE;
    unique case (action)
      ACT_MARK: begin
        effective = 1'b1;
        op        = OP_MARK;
      end
      ACT_LOAD: begin
        effective = (operand_count == TWO_OPERANDS);
        op        = OP_LOAD;
      end
      ACT_STORE: begin
        effective = (operand_count == TWO_OPERANDS);
        op        = OP_STORE;
      end
      ACT_MOVE: begin
        effective = (operand_count == TWO_OPERANDS) && (written_register != '0);
        op        = OP_MOVE;
      end
      ACT_USE: begin
        effective = 1'b1;
        op        = OP_USE;
      end
      default: effective = 1'b0;
    endcase
  end

  assign push    = in_valid && in_ready && effective;
  assign item.op = op;
  assign item.ia = instruction_address;
  assign item.ma = mem_address;
  assign item.pr = primary_register;
  assign item.wr = written_register;

endmodule

FILE: rtl/rmtt_back.sv
module rmtt_back
  import rmtt_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              clearing,
  input  logic [ADDR_W-1:0] threshold,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              has_report,
  output logic [1:0]        report_kind,
  output logic [ADDR_W-1:0] reported_address,
  output logic [ADDR_W-1:0] reported_instruction,
  output logic              table_overflow
);

`include "register_memory_taint_tracker_top_defines.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t            st;
  logic [ADDR_W:0]   mem [TABLE_DEPTH];
  logic [IDX_W-1:0]  clr_idx;
  logic [IDX_W-1:0]  scan_idx;
  logic              issuing;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [ADDR_W:0]   rd_data;
  logic              found;
  logic [IDX_W-1:0]  match_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [MASK_W-1:0] mask;
  logic [MASK_W-1:0] mask_next;

  logic              scan_op;
  logic              pt;
  logic              wt;
  logic              rep;
  logic              rep_shown;
  logic [1:0]        kind;
  logic              ovf;
  logic              x_we;
  logic [IDX_W-1:0]  x_wa;
  logic [ADDR_W:0]   x_wd;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [ADDR_W:0]   mem_wd;
  logic              fin_ok;
  logic              finish;

  assign clearing = (st == S_CLEAR);
  assign scan_op  = (q_item.op == OP_MARK) || (q_item.op == OP_LOAD) ||
                    (q_item.op == OP_STORE);
  assign fin_ok   = !out_valid || out_ready;
  assign finish   = ((st == S_IDLE) && q_valid && !scan_op) || (st == S_EXEC);
  assign q_pop    = finish && fin_ok;

  // carry out the head item using the scan result where it needs one
  always_comb begin
    pt        = is_tainted(mask, q_item.pr);
    wt        = is_tainted(mask, q_item.wr);
    rep       = 1'b0;
    kind      = RK_READ;
    ovf       = 1'b0;
    mask_next = mask;
    x_we      = 1'b0;
    x_wa      = free_idx;
    x_wd      = {1'b1, q_item.ma};
    case (q_item.op)
      OP_MARK: begin
        if (!found) begin
          if (free_found) x_we = 1'b1;
          else ovf = 1'b1;
        end
      end
      OP_LOAD: begin
        if (found) begin
          rep = 1'b1;
          if (!pt) mask_next = mask | span_of(q_item.pr);
        end else if (pt) begin
          rep       = 1'b1;
          mask_next = mask & ~span_of(q_item.pr);
        end
      end
      OP_STORE: begin
        kind = RK_WRITE;
        if (found) begin
          rep = 1'b1;
          if (!pt) begin
            x_we = 1'b1;
            x_wa = match_idx;
            x_wd = '0;
          end
        end else if (pt) begin
          rep = 1'b1;
          if (free_found) x_we = 1'b1;
          else ovf = 1'b1;
        end
      end
      OP_MOVE: begin
        kind = RK_SPREAD;
        if (wt && !pt) begin
          rep       = 1'b1;
          mask_next = mask & ~span_of(q_item.wr);
        end else if (!wt && pt) begin
          rep       = 1'b1;
          mask_next = mask | span_of(q_item.wr);
        end
      end
      default: begin
        kind = RK_FOLLOW;
        rep  = pt;
      end
    endcase
    rep_shown = rep && !(q_item.ia > threshold);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = x_wa;
    mem_wd = x_wd;
    if (st == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_idx;
      mem_wd = '0;
    end else if (st == S_EXEC && fin_ok) begin
      mem_we = x_we;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[scan_idx];
    rd_idx  <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_CLEAR;
      clr_idx    <= '0;
      scan_idx   <= '0;
      issuing    <= 1'b0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      mask       <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= issuing;
      if (issuing) begin
        scan_idx <= scan_idx + 1'b1;
        if (scan_idx == LAST) issuing <= 1'b0;
      end
      unique case (st)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST) st <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid && scan_op) begin
            st         <= S_SCAN;
            scan_idx   <= '0;
            issuing    <= 1'b1;
            found      <= 1'b0;
            free_found <= 1'b0;
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (rd_data[ADDR_W] && rd_data[ADDR_W-1:0] == q_item.ma) begin
              found     <= 1'b1;
              match_idx <= rd_idx;
            end
            if (!rd_data[ADDR_W] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rd_idx == LAST) st <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fin_ok) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
      if (q_pop) begin
        mask      <= mask_next;
        out_valid <= rep_shown || ovf;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      has_report           <= rep_shown;
      report_kind          <= rep_shown ? kind : RK_READ;
      reported_address     <= (rep_shown && (q_item.op == OP_LOAD || q_item.op == OP_STORE))
                              ? q_item.ma : '0;
      reported_instruction <= rep_shown ? q_item.ia : '0;
      table_overflow       <= ovf;
    end
  end

  `RMTT_ASSERT_NOW(a_no_write_idle, st == S_IDLE, !mem_we)
  `RMTT_ASSERT_NOW(a_pop_has_room, q_pop, fin_ok && q_valid)
  `RMTT_ASSERT_NEXT(a_scan_ends, st == S_SCAN && rd_vld && rd_idx == LAST, st == S_EXEC)

endmodule

FILE: rtl/register_memory_taint_tracker_top.sv
// Taint tracker for register groups and memory bytes. After reset the address table is
// swept clear, during which no event is taken. Register-only events (move, use) are
// carried out from the queue head without a table search; events that touch the address
// table (mark, load, store) first wait for a search of the table memory, one entry per
// cycle. A two-entry queue sits between the event decoder and the
// executor, and results leave through an output register, so while a result waits the queue
// keeps taking events until it fills.
module register_memory_taint_tracker_top
  import rmtt_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        action,
  input  logic [ADDR_W-1:0] instruction_address,
  input  logic [ADDR_W-1:0] mem_address,
  input  logic [3:0]        operand_count,
  input  logic [REG_W-1:0]  primary_register,
  input  logic [REG_W-1:0]  written_register,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              has_report,
  output logic [1:0]        report_kind,
  output logic [ADDR_W-1:0] reported_address,
  output logic [ADDR_W-1:0] reported_instruction,
  output logic              table_overflow
);

  logic [ADDR_W-1:0] threshold;
  logic              push;
  item_t             push_item;
  logic              pop;
  item_t             head;
  logic              q_valid;
  logic              q_full;
  logic              clearing;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? {16'b0, threshold} : 64'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= LIB_RESET;
    end else if (psel && penable && pwrite && pready && paddr[3] == 1'b0) begin
      threshold <= pwdata[ADDR_W-1:0];
    end
  end

  rmtt_front u_front (
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .action              (action),
    .instruction_address (instruction_address),
    .mem_address         (mem_address),
    .operand_count       (operand_count),
    .primary_register    (primary_register),
    .written_register    (written_register),
    .q_full              (q_full),
    .clearing            (clearing),
    .push                (push),
    .item                (push_item)
  );

  rmtt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  rmtt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_valid              (q_valid),
    .q_item               (head),
    .q_pop                (pop),
    .clearing             (clearing),
    .threshold            (threshold),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .has_report           (has_report),
    .report_kind          (report_kind),
    .reported_address     (reported_address),
    .reported_instruction (reported_instruction),
    .table_overflow       (table_overflow)
  );

endmodule

FILE: sim/register_memory_taint_tracker_top_tb.sv
module register_memory_taint_tracker_top_tb
  import rmtt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  localparam int DRAIN_CYCLES = 3 * DEPTH + 40;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam logic [3:0] THRESH_ADDR = 4'd0;
  localparam logic [2:0] ACT_SPARE = 3'd5;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  localparam logic [REG_W-1:0] R_NONE = 5'd0;
  localparam logic [REG_W-1:0] R_RAX = 5'd1;
  localparam logic [REG_W-1:0] R_EAX = 5'd2;
  localparam logic [REG_W-1:0] R_AL = 5'd5;
  localparam logic [REG_W-1:0] R_RBX = 5'd6;
  localparam logic [REG_W-1:0] R_CL = 5'd15;
  localparam logic [REG_W-1:0] R_SIL = 5'd28;
  localparam logic [REG_W-1:0] R_UNTRACKED = 5'd29;
  localparam logic [REG_W-1:0] R_TOP = 5'd31;

  typedef struct {
    logic              rep;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] ia;
    logic              ovf;
  } taint_report_t;

  class taint_scoreboard;
    logic [MASK_W-1:0] reg_mask;
    logic [ADDR_W-1:0] addr_store[DEPTH];
    logic              addr_valid[DEPTH];
    logic [ADDR_W-1:0] threshold;
    taint_report_t     pending_reports[$];
    int                mismatches;

    function new();
      reg_mask = '0;
      threshold = LIB_RESET;
      mismatches = 0;
      foreach (addr_valid[i]) addr_valid[i] = 1'b0;
    endfunction

    function bit tainted(logic [REG_W-1:0] r);
      if (r == 0 || r > 28) return 1'b0;
      return reg_mask[r-1];
    endfunction

    function logic [MASK_W-1:0] group_span(logic [REG_W-1:0] r);
      int last;
      logic [MASK_W-1:0] s;
      s = '0;
      if (r == 0 || r > 28) return s;
      if (r <= 5) last = 5;
      else if (r <= 10) last = 10;
      else if (r <= 15) last = 15;
      else if (r <= 20) last = 20;
      else if (r <= 24) last = 24;
      else last = 28;
      for (int c = r; c <= last; c++) s[c-1] = 1'b1;
      return s;
    endfunction

    function void taint_reg(logic [REG_W-1:0] r);
      if (!tainted(r)) reg_mask |= group_span(r);
    endfunction

    function void untaint_reg(logic [REG_W-1:0] r);
      reg_mask &= ~group_span(r);
    endfunction

    function bit holds(logic [ADDR_W-1:0] a);
      for (int i = 0; i < DEPTH; i++)
        if (addr_valid[i] && addr_store[i] == a) return 1'b1;
      return 1'b0;
    endfunction

    // returns 0 when no entry is free
    function bit insert_addr(logic [ADDR_W-1:0] a);
      if (holds(a)) return 1'b1;
      for (int i = 0; i < DEPTH; i++)
        if (!addr_valid[i]) begin
          addr_valid[i] = 1'b1;
          addr_store[i] = a;
          return 1'b1;
        end
      return 1'b0;
    endfunction

    function void drop_addr(logic [ADDR_W-1:0] a);
      for (int i = 0; i < DEPTH; i++)
        if (addr_valid[i] && addr_store[i] == a) addr_valid[i] = 1'b0;
    endfunction

    function void note_word(logic [2:0] act, logic [ADDR_W-1:0] ia, logic [ADDR_W-1:0] ma,
                            logic [3:0] ops, logic [REG_W-1:0] pr, logic [REG_W-1:0] wr);
      taint_report_t r;
      r = '{1'b0, RK_READ, '0, '0, 1'b0};
      case (act)
        ACT_MARK: r.ovf = !insert_addr(ma);
        ACT_LOAD: if (ops == TWO_OPERANDS) begin
          if (holds(ma)) begin
            r.rep = 1'b1; r.kind = RK_READ; r.raddr = ma;
            taint_reg(pr);
          end else if (tainted(pr)) begin
            r.rep = 1'b1; r.kind = RK_READ; r.raddr = ma;
            untaint_reg(pr);
          end
        end
        ACT_STORE: if (ops == TWO_OPERANDS) begin
          if (holds(ma)) begin
            r.rep = 1'b1; r.kind = RK_WRITE; r.raddr = ma;
            if (!tainted(pr)) drop_addr(ma);
          end else if (tainted(pr)) begin
            r.rep = 1'b1; r.kind = RK_WRITE; r.raddr = ma;
            r.ovf = !insert_addr(ma);
          end
        end
        ACT_MOVE: if (ops == TWO_OPERANDS && wr != R_NONE) begin
          if (tainted(wr) && !tainted(pr)) begin
            r.rep = 1'b1; r.kind = RK_SPREAD;
            untaint_reg(wr);
          end else if (!tainted(wr) && tainted(pr)) begin
            r.rep = 1'b1; r.kind = RK_SPREAD;
            taint_reg(wr);
          end
        end
        ACT_USE: if (tainted(pr)) begin
          r.rep = 1'b1; r.kind = RK_FOLLOW;
        end
        default: ;
      endcase
      // library code: state still changes, report dropped
      if (r.rep && ia > threshold) r.rep = 1'b0;
      if (!r.rep) begin
        r.kind = RK_READ; r.raddr = '0;
      end else r.ia = ia;
      if (r.rep || r.ovf) pending_reports = {pending_reports, r};
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_word(taint_report_t got);
      taint_report_t want;
      if (pending_reports.size() == 0) begin
        flag($sformatf("unexpected word rep=%0b kind=%0d addr=%h ia=%h ovf=%0b",
                       got.rep, got.kind, got.raddr, got.ia, got.ovf));
        return;
      end
      want = pending_reports.pop_front();
      if (got.rep !== want.rep)
        flag($sformatf("has_report exp %0b got %0b", want.rep, got.rep));
      if (got.kind !== want.kind)
        flag($sformatf("report_kind exp %0d got %0d", want.kind, got.kind));
      if (got.raddr !== want.raddr)
        flag($sformatf("reported_address exp %h got %h", want.raddr, got.raddr));
      if (got.ia !== want.ia)
        flag($sformatf("reported_instruction exp %h got %h", want.ia, got.ia));
      if (got.ovf !== want.ovf)
        flag($sformatf("table_overflow exp %0b got %0b", want.ovf, got.ovf));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] action = '0;
  logic [ADDR_W-1:0] instruction_address = '0;
  logic [ADDR_W-1:0] mem_address = '0;
  logic [3:0] operand_count = '0;
  logic [REG_W-1:0] primary_register = '0;
  logic [REG_W-1:0] written_register = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic has_report;
  logic [1:0] report_kind;
  logic [ADDR_W-1:0] reported_address;
  logic [ADDR_W-1:0] reported_instruction;
  logic table_overflow;

  register_memory_taint_tracker_top #(.TABLE_DEPTH(DEPTH)) DUT (.*);

  taint_scoreboard sb = new();
  longint cycles = 0;
  int stall_left = 0;
  logic [ADDR_W-1:0] addr_pool[12];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check the word, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word('{has_report, report_kind, reported_address, reported_instruction,
                      table_overflow});
    if (rst) out_ready <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) out_ready <= 1'b1;
      else if (r < 19) begin
        stall_left <= $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        stall_left <= $urandom_range(20, 150);
        out_ready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 19) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_event(logic [2:0] act, logic [ADDR_W-1:0] ia, logic [ADDR_W-1:0] ma,
                            logic [3:0] ops, logic [REG_W-1:0] pr, logic [REG_W-1:0] wr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action <= act;
    instruction_address <= ia;
    mem_address <= ma;
    operand_count <= ops;
    primary_register <= pr;
    written_register <= wr;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(act, ia, ma, ops, pr, wr);
  endtask

  // every expected word in, then let silent table events finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [ADDR_W-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= THRESH_ADDR;
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.threshold = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_ia();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 48'({$urandom(), $urandom()} % (sb.threshold + 48'd1));
    if (r == 6) return sb.threshold;
    if (r == 7) return sb.threshold + 48'd1;
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [REG_W-1:0] pick_reg();
    if ($urandom_range(0, 9) == 0) return 5'($urandom());
    return 5'($urandom_range(1, 28));
  endfunction

  task automatic random_event();
    logic [2:0] act;
    logic [ADDR_W-1:0] ma;
    logic [3:0] ops;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) act = ACT_MARK;
    else if (r < 40) act = ACT_LOAD;
    else if (r < 60) act = ACT_STORE;
    else if (r < 80) act = ACT_MOVE;
    else if (r < 96) act = ACT_USE;
    else act = ACT_SPARE + 3'($urandom_range(0, 2));
    if ($urandom_range(0, 9) < 8) ma = addr_pool[$urandom_range(0, 11)];
    else ma = 48'({$urandom(), $urandom()});
    ops = ($urandom_range(0, 9) < 9) ? TWO_OPERANDS : 4'($urandom());
    send_event(act, pick_ia(), ma, ops, pick_reg(), pick_reg());
  endtask

  initial begin
    logic [ADDR_W-1:0] a_addr, b_addr, c_addr;
    logic [ADDR_W-1:0] settings[4];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (addr_pool[i]) addr_pool[i] = 48'({$urandom(), $urandom()});
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_MAX;
    a_addr = addr_pool[2];
    b_addr = addr_pool[3];
    c_addr = addr_pool[4];
    write_threshold(LIB_RESET);

    // directed: flows through loads, moves, stores and uses
    send_event(ACT_MARK, '0, a_addr, '0, R_NONE, R_NONE);
    send_event(ACT_MARK, '0, a_addr, '0, R_NONE, R_NONE);
    send_event(ACT_LOAD, 48'h1000, a_addr, TWO_OPERANDS, R_RAX, R_NONE);
    send_event(ACT_USE, 48'h1004, '0, '0, R_EAX, R_NONE);
    send_event(ACT_USE, 48'h1008, '0, '0, R_AL, R_NONE);
    send_event(ACT_MOVE, 48'h100c, '0, TWO_OPERANDS, R_RAX, R_RBX);
    send_event(ACT_STORE, 48'h1010, b_addr, TWO_OPERANDS, R_RBX, R_NONE);
    send_event(ACT_LOAD, 48'h1014, b_addr, 4'd3, R_CL, R_NONE);
    send_event(ACT_LOAD, 48'h1018, c_addr, TWO_OPERANDS, R_EAX, R_NONE);
    send_event(ACT_MOVE, 48'h101c, '0, TWO_OPERANDS, R_RAX, R_UNTRACKED);
    send_event(ACT_MOVE, 48'h1020, '0, TWO_OPERANDS, R_RBX, R_NONE);
    send_event(ACT_MOVE, 48'h1024, '0, TWO_OPERANDS, R_SIL, R_RBX);
    send_event(ACT_USE, LIB_RESET + 48'd1, '0, '0, R_RAX, R_NONE);
    send_event(ACT_USE, ADDR_MAX, ADDR_MAX, 4'hf, R_TOP, R_TOP);
    send_event(ACT_SPARE, 48'h1028, a_addr, TWO_OPERANDS, R_RAX, R_RAX);
    send_event(ACT_SPARE + 3'd2, 48'h102c, a_addr, TWO_OPERANDS, R_RAX, R_RAX);
    send_event(ACT_STORE, 48'h1030, a_addr, TWO_OPERANDS, R_CL, R_NONE);
    send_event(ACT_MARK, '0, addr_pool[0], '0, R_NONE, R_NONE);
    send_event(ACT_MARK, '0, addr_pool[1], '0, R_NONE, R_NONE);
    send_event(ACT_LOAD, LIB_RESET, addr_pool[1], TWO_OPERANDS, R_SIL, R_NONE);
    send_event(ACT_STORE, LIB_RESET + 48'd1, addr_pool[0], TWO_OPERANDS, R_NONE, R_NONE);

    // fill the table past its end, then empty it again
    wait_idle();
    for (int i = 0; i <= DEPTH; i++)
      send_event(ACT_MARK, '0, {32'h00a5_0000, 16'(i)}, '0, R_NONE, R_NONE);
    send_event(ACT_STORE, 48'h2000, 48'h0000_dead_0001, TWO_OPERANDS, R_SIL, R_NONE);
    for (int i = 0; i <= DEPTH; i++)
      send_event(ACT_STORE, 48'h2004, {32'h00a5_0000, 16'(i)}, TWO_OPERANDS, R_NONE, R_NONE);
    send_event(ACT_STORE, 48'h2008, addr_pool[1], TWO_OPERANDS, R_NONE, R_NONE);

    settings[0] = LIB_RESET;
    settings[1] = '0;
    settings[2] = ADDR_MAX;
    settings[3] = 48'({$urandom(), $urandom()});
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_threshold(settings[p]);
      for (int n = 0; n < 270; n++) random_event();
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/rmtt_pkg.sv
rtl/rmtt_queue.sv
rtl/rmtt_front.sv
rtl/rmtt_back.sv
rtl/register_memory_taint_tracker_top.sv
sim/register_memory_taint_tracker_top_tb.sv
